// File: sv/wsd_pkg.sv
// Shared constants for the websocket frame deframer.
// No dependencies; imported by the core and by its testbench.
package wsd_pkg;

    localparam int LENGTH_BITS = 64;

    localparam logic [7:0] HDR_TOP_BIT     = 8'h80;
    localparam logic [7:0] HDR_OPCODE_MASK = 8'h0F;
    localparam logic [7:0] HDR_LEN_MASK    = 8'h7F;
    localparam logic [6:0] LEN7_EXT16      = 7'd126;
    localparam logic [6:0] LEN7_EXT64      = 7'd127;

    localparam logic [2:0] EXT16_BYTES     = 3'd2;
    localparam logic [2:0] EXT64_BYTES     = 3'd0;
    localparam logic [2:0] KEY_BYTES       = 3'd4;

    typedef logic [LENGTH_BITS-1:0] frame_len_t;

endpackage

// File: sv/websocket_frame_deframer_core.sv
// Results are registered: an accepted input word's result word is on m_* in the next cycle.
// Throughput: one input word per cycle; s_ready drops only while a result is stalled.
// Header words produce no result, except the last one of an empty frame; each payload word gives one.
// Reset: aresetn is synchronous and active low; it returns the parser to the
// first header word and empties the output register.
// Depends on wsd_pkg.
module websocket_frame_deframer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_stream_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_payload_byte,
    output logic       m_data_valid,
    output logic [3:0] m_frame_opcode,
    output logic       m_frame_fin,
    output logic       m_frame_last
);
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_EXT,
        PH_KEY,
        PH_DATA
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [2:0] hdr_count_reg, hdr_count_next;
    logic       ext_long_reg, ext_long_next;
    logic       fin_reg, fin_next;
    logic [3:0] opcode_reg, opcode_next;
    logic       mask_reg, mask_next;
    frame_len_t remain_reg, remain_next;
    logic [31:0] key_reg, key_next;
    logic [1:0] key_idx_reg, key_idx_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_byte_reg, m_byte_next;
    logic       m_dvalid_reg, m_dvalid_next;
    logic [3:0] m_opcode_reg, m_opcode_next;
    logic       m_fin_reg, m_fin_next;
    logic       m_last_reg, m_last_next;

    logic       accept;
    logic       emit;
    logic [7:0] emit_byte;
    logic       emit_dvalid;
    logic       emit_last;
    logic [6:0] len7;
    logic [2:0] count_inc;
    logic [7:0] key_byte;
    frame_len_t hdr_len;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign len7      = 7'(s_stream_byte & HDR_LEN_MASK);
    assign count_inc = hdr_count_reg + 3'd1;
    assign key_byte  = key_reg[{~key_idx_reg, 3'b000} +: 8];

    always_comb begin
        phase_next     = phase_reg;
        hdr_count_next = hdr_count_reg;
        ext_long_next  = ext_long_reg;
        fin_next       = fin_reg;
        opcode_next    = opcode_reg;
        mask_next      = mask_reg;
        remain_next    = remain_reg;
        key_next       = key_reg;
        key_idx_next   = key_idx_reg;
        emit           = 1'b0;
        emit_byte      = 8'd0;
        emit_dvalid    = 1'b0;
        emit_last      = 1'b0;
        hdr_len        = remain_reg;

        if (accept) begin
            case (phase_reg)
                PH_HDR1: begin
                    fin_next    = (s_stream_byte & HDR_TOP_BIT) == HDR_TOP_BIT;
                    opcode_next = 4'(s_stream_byte & HDR_OPCODE_MASK);
                    phase_next  = PH_HDR2;
                end
                PH_HDR2: begin
                    mask_next      = (s_stream_byte & HDR_TOP_BIT) == HDR_TOP_BIT;
                    key_next       = '0;
                    hdr_count_next = '0;
                    key_idx_next   = '0;
                    remain_next    = '0;
                    if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
                        ext_long_next = (len7 == LEN7_EXT64);
                        phase_next    = PH_EXT;
                    end else begin
                        hdr_len     = LENGTH_BITS'(len7);
                        remain_next = hdr_len;
                        if (mask_next) begin
                            phase_next = PH_KEY;
                        end else if (hdr_len == '0) begin
                            phase_next = PH_HDR1;
                            emit       = 1'b1;
                            emit_last  = 1'b1;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_EXT: begin
                    hdr_len        = {remain_reg[LENGTH_BITS-9:0], s_stream_byte};
                    remain_next    = hdr_len;
                    hdr_count_next = count_inc;
                    if (count_inc == (ext_long_reg ? EXT64_BYTES : EXT16_BYTES)) begin
                        hdr_count_next = '0;
                        key_idx_next   = '0;
                        if (mask_reg) begin
                            phase_next = PH_KEY;
                        end else if (hdr_len == '0) begin
                            phase_next = PH_HDR1;
                            emit       = 1'b1;
                            emit_last  = 1'b1;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_KEY: begin
                    key_next       = {key_reg[23:0], s_stream_byte};
                    hdr_count_next = count_inc;
                    if (count_inc == KEY_BYTES) begin
                        hdr_count_next = '0;
                        if (remain_reg == '0) begin
                            phase_next = PH_HDR1;
                            emit       = 1'b1;
                            emit_last  = 1'b1;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    emit         = 1'b1;
                    emit_dvalid  = 1'b1;
                    emit_byte    = s_stream_byte ^ key_byte;
                    key_idx_next = key_idx_reg + 2'd1;
                    remain_next  = remain_reg - LENGTH_BITS'(1);
                    if (remain_reg == LENGTH_BITS'(1)) begin
                        emit_last  = 1'b1;
                        phase_next = PH_HDR1;
                    end
                end
                default: begin
                    phase_next = PH_HDR1;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_byte_next   = m_byte_reg;
        m_dvalid_next = m_dvalid_reg;
        m_opcode_next = m_opcode_reg;
        m_fin_next    = m_fin_reg;
        m_last_next   = m_last_reg;
        if (emit) begin
            m_valid_next  = 1'b1;
            m_byte_next   = emit_byte;
            m_dvalid_next = emit_dvalid;
            m_opcode_next = opcode_reg;
            m_fin_next    = fin_reg;
            m_last_next   = emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HDR1;
            hdr_count_reg <= '0;
            ext_long_reg  <= 1'b0;
            fin_reg       <= 1'b0;
            opcode_reg    <= '0;
            mask_reg      <= 1'b0;
            remain_reg    <= '0;
            key_reg       <= '0;
            key_idx_reg   <= '0;
            m_valid_reg   <= 1'b0;
            m_byte_reg    <= '0;
            m_dvalid_reg  <= 1'b0;
            m_opcode_reg  <= '0;
            m_fin_reg     <= 1'b0;
            m_last_reg    <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            hdr_count_reg <= hdr_count_next;
            ext_long_reg  <= ext_long_next;
            fin_reg       <= fin_next;
            opcode_reg    <= opcode_next;
            mask_reg      <= mask_next;
            remain_reg    <= remain_next;
            key_reg       <= key_next;
            key_idx_reg   <= key_idx_next;
            m_valid_reg   <= m_valid_next;
            m_byte_reg    <= m_byte_next;
            m_dvalid_reg  <= m_dvalid_next;
            m_opcode_reg  <= m_opcode_next;
            m_fin_reg     <= m_fin_next;
            m_last_reg    <= m_last_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_payload_byte = m_byte_reg;
    assign m_data_valid   = m_dvalid_reg;
    assign m_frame_opcode = m_opcode_reg;
    assign m_frame_fin    = m_fin_reg;
    assign m_frame_last   = m_last_reg;

endmodule

// File: sv/wsd_checker.sv
// Port-level checks for websocket_frame_deframer_core, with the bind that attaches them.
// Depends on the core's port list only.
module wsd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_stream_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_payload_byte,
    input logic       m_data_valid,
    input logic [3:0] m_frame_opcode,
    input logic       m_frame_fin,
    input logic       m_frame_last
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload_byte)
            && $stable(m_data_valid) && $stable(m_frame_opcode)
            && $stable(m_frame_fin) && $stable(m_frame_last))
        else $error("stalled result word changed");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_stream_byte))
        else $error("stalled input word changed");

    a_empty_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data_valid |-> m_payload_byte == 8'd0 && m_frame_last)
        else $error("empty-frame marker malformed");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (.*);

// File: tb/websocket_frame_deframer_core_tb.sv
// Self-checking bench for websocket_frame_deframer_core: frames are built byte by byte,
// unmasked results are predicted in step with each accepted byte and checked in order.
// Depends on wsd_pkg and websocket_frame_deframer_core.
module websocket_frame_deframer_core_tb;
    import wsd_pkg::*;

    localparam logic [3:0] OP_CONT     = 4'h0;
    localparam logic [3:0] OP_TEXT     = 4'h1;
    localparam logic [3:0] OP_BINARY   = 4'h2;
    localparam logic [3:0] OP_CLOSE    = 4'h8;
    localparam logic [3:0] OP_PING     = 4'h9;
    localparam logic [3:0] OP_RESERVED = 4'hF;

    localparam logic [1:0] FORM_SHORT = 2'd0;
    localparam logic [1:0] FORM_EXT16 = 2'd1;
    localparam logic [1:0] FORM_EXT64 = 2'd2;

    typedef enum logic [2:0] {
        P_FIRST, P_SECOND, P_EXTLEN, P_KEY, P_PAYLOAD
    } hdr_phase_t;

    typedef struct packed {
        logic [7:0] payload;
        logic       present;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
    } deframe_word_t;

    logic       aclk;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_stream_byte = 8'h00;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [7:0] m_payload_byte;
    logic       m_data_valid;
    logic [3:0] m_frame_opcode;
    logic       m_frame_fin;
    logic       m_frame_last;

    hdr_phase_t  hdr_phase  = P_FIRST;
    logic [2:0]  hdr_count  = 3'd0;
    logic [2:0]  ext_needed = 3'd0;
    logic        cur_fin    = 1'b0;
    logic [3:0]  cur_opcode = 4'h0;
    logic        cur_masked = 1'b0;
    frame_len_t  cur_length = '0;
    logic [31:0] cur_key    = 32'h0;
    logic [63:0] cur_sent   = 64'h0;

    deframe_word_t pending_words[$];
    int fault_count   = 0;
    int words_sent    = 0;
    int stall_request = 0;
    int stall_left    = 0;
    int rx_calm_left  = 0;
    bit rx_calm       = 1'b0;
    int tx_calm_left  = 0;
    bit tx_calm       = 1'b0;

    websocket_frame_deframer_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_stream_byte (s_stream_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_payload_byte(m_payload_byte),
        .m_data_valid  (m_data_valid),
        .m_frame_opcode(m_frame_opcode),
        .m_frame_fin   (m_frame_fin),
        .m_frame_last  (m_frame_last)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(12 * 1_000_000);
        $display("websocket_frame_deframer_core_tb NOT OK");
        $finish;
    end

    function automatic void push_word(logic [7:0] data, logic present, logic last);
        pending_words.push_back('{payload: data, present: present, opcode: cur_opcode,
                                  fin: cur_fin, last: last});
    endfunction

    function automatic void header_complete();
        hdr_count = 3'd0;
        cur_sent  = 64'h0;
        if (cur_masked) begin
            hdr_phase = P_KEY;
        end else if (cur_length == 0) begin
            hdr_phase = P_FIRST;
            push_word(8'h00, 1'b0, 1'b1);
        end else begin
            hdr_phase = P_PAYLOAD;
        end
    endfunction

    function automatic void deframe_byte(logic [7:0] b);
        logic [6:0] len7;
        logic [1:0] slot;
        logic [7:0] key_byte;
        case (hdr_phase)
            P_FIRST: begin
                cur_fin    = (b & HDR_TOP_BIT) != 0;
                cur_opcode = 4'(b & HDR_OPCODE_MASK);
                hdr_phase  = P_SECOND;
            end
            P_SECOND: begin
                cur_masked = (b & HDR_TOP_BIT) != 0;
                len7       = 7'(b & HDR_LEN_MASK);
                cur_key    = 32'h0;
                hdr_count  = 3'd0;
                cur_length = '0;
                if (len7 == LEN7_EXT16) begin
                    ext_needed = EXT16_BYTES;
                    hdr_phase  = P_EXTLEN;
                end else if (len7 == LEN7_EXT64) begin
                    ext_needed = EXT64_BYTES;
                    hdr_phase  = P_EXTLEN;
                end else begin
                    cur_length = frame_len_t'(len7);
                    header_complete();
                end
            end
            P_EXTLEN: begin
                cur_length = {cur_length[LENGTH_BITS-9:0], b};
                hdr_count  = hdr_count + 3'd1;
                if (hdr_count == ext_needed) header_complete();
            end
            P_KEY: begin
                cur_key   = {cur_key[23:0], b};
                hdr_count = hdr_count + 3'd1;
                if (hdr_count == KEY_BYTES) begin
                    hdr_count = 3'd0;
                    if (cur_length == 0) begin
                        hdr_phase = P_FIRST;
                        push_word(8'h00, 1'b0, 1'b1);
                    end else begin
                        hdr_phase = P_PAYLOAD;
                    end
                end
            end
            default: begin
                slot     = cur_sent[1:0];
                key_byte = cur_key[8*(3-slot) +: 8];
                cur_sent = cur_sent + 64'd1;
                if (cur_sent == cur_length) begin
                    hdr_phase = P_FIRST;
                    push_word(b ^ key_byte, 1'b1, 1'b1);
                end else begin
                    push_word(b ^ key_byte, 1'b1, 1'b0);
                end
            end
        endcase
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: random stalls with calm stretches; the longest holds come from stall_request.
    always @(posedge aclk) begin
        if (stall_request > 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            if (rx_calm_left == 0) begin
                rx_calm      = ($urandom_range(0, 3) == 0);
                rx_calm_left = $urandom_range(50, 300);
            end
            rx_calm_left = rx_calm_left - 1;
            if (!rx_calm && $urandom_range(0, 99) < 25) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                fault_count++;
                $display("%0t: unexpected word: byte %02h dv %0b op %0h fin %0b last %0b",
                         $time, m_payload_byte, m_data_valid, m_frame_opcode,
                         m_frame_fin, m_frame_last);
            end else begin
                if (pending_words[0] != {m_payload_byte, m_data_valid, m_frame_opcode,
                                         m_frame_fin, m_frame_last}) begin
                    fault_count++;
                    $display({"%0t: mismatch: expected byte %02h dv %0b op %0h fin %0b ",
                              "last %0b, got byte %02h dv %0b op %0h fin %0b last %0b"},
                             $time, pending_words[0].payload, pending_words[0].present,
                             pending_words[0].opcode, pending_words[0].fin,
                             pending_words[0].last, m_payload_byte, m_data_valid,
                             m_frame_opcode, m_frame_fin, m_frame_last);
                end
                void'(pending_words.pop_front());
            end
        end
    end

    // Valid stays high after acceptance; callers that pause drop it through drain_results.
    task automatic send_word(input logic [7:0] b);
        int gap;
        if (tx_calm_left == 0) begin
            tx_calm      = ($urandom_range(0, 3) == 0);
            tx_calm_left = $urandom_range(20, 150);
        end
        tx_calm_left = tx_calm_left - 1;
        gap = tx_calm ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_stream_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        deframe_byte(b);
        words_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words.size() != 0) @(posedge aclk);
    endtask

    task automatic send_frame(input logic [7:0] first, input logic masked,
                              input logic [1:0] form, input frame_len_t length,
                              input logic [31:0] key, input int payload_words);
        int i;
        send_word(first);
        if (form == FORM_EXT16) begin
            send_word({masked, LEN7_EXT16});
            send_word(length[15:8]);
            send_word(length[7:0]);
        end else if (form == FORM_EXT64) begin
            send_word({masked, LEN7_EXT64});
            for (i = 7; i >= 0; i--) send_word(length[8*i +: 8]);
        end else begin
            send_word({masked, length[6:0]});
        end
        if (masked) begin
            for (i = 3; i >= 0; i--) send_word(key[8*i +: 8]);
        end
        for (i = 0; i < payload_words; i++) send_word(8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_frame();
        int r;
        logic [1:0] form;
        frame_len_t length;
        r = $urandom_range(0, 99);
        form = (r < 65) ? FORM_SHORT : (r < 85) ? FORM_EXT16 : FORM_EXT64;
        r = $urandom_range(0, 99);
        if (r < 70)
            length = frame_len_t'($urandom_range(0, 8));
        else if (r < 95 || form == FORM_SHORT)
            length = frame_len_t'($urandom_range(0, 125));
        else
            length = frame_len_t'($urandom_range(126, 600));
        send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), form, length,
                   $urandom(), int'(length));
    endtask

    task automatic test_basic_frames();
        send_frame({1'b1, 3'b000, OP_TEXT}, 1'b0, FORM_SHORT, frame_len_t'(1), 32'h0, 1);
        send_frame({1'b0, 3'b000, OP_RESERVED}, 1'b1, FORM_SHORT, frame_len_t'(0),
                   32'hFFFF_FFFF, 0);
        send_frame({1'b1, 3'b111, OP_CONT}, 1'b0, FORM_SHORT, frame_len_t'(0), 32'h0, 0);
        send_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, FORM_EXT16, frame_len_t'(2),
                   32'h1234_5678, 2);
        send_frame({1'b0, 3'b000, OP_CLOSE}, 1'b0, FORM_EXT16, frame_len_t'(0), 32'h0, 0);
        send_frame({1'b1, 3'b000, OP_PING}, 1'b0, FORM_EXT64, frame_len_t'(1), 32'h0, 1);
    endtask

    task automatic test_random_frames();
        int start;
        start = words_sent;
        while (words_sent - start < 600) send_random_frame();
    endtask

    task automatic test_output_backpressure();
        stall_request = 400;
        send_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, FORM_SHORT, frame_len_t'(60),
                   $urandom(), 60);
        send_random_frame();
    endtask

    task automatic test_pause_until_drained();
        int round;
        for (round = 0; round < 3; round++) begin
            send_random_frame();
            send_random_frame();
            drain_results();
            repeat ($urandom_range(10, 60)) @(posedge aclk);
        end
    endtask

    // Length with its top bit set never completes; keep it last.
    task automatic test_oversized_length();
        send_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, FORM_EXT64, {LENGTH_BITS{1'b1}},
                   $urandom(), 200);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_frames();
        test_random_frames();
        test_output_backpressure();
        test_pause_until_drained();
        test_oversized_length();
        drain_results();
        repeat (10) @(posedge aclk);
        if (fault_count == 0 && pending_words.size() == 0) begin
            $display("websocket_frame_deframer_core_tb OK");
        end else begin
            $display("websocket_frame_deframer_core_tb NOT OK");
        end
        $finish;
    end

endmodule
